// ----- sv/blm_pkg.sv -----
`default_nettype none
package blm_pkg;

  localparam int VALUE_BITS = 48;
  localparam int FRAC_BITS  = 32;
  localparam int GOLD_BITS  = 64;
  localparam int PROD_W     = VALUE_BITS + GOLD_BITS;
  localparam int QUOT_W     = VALUE_BITS + FRAC_BITS;
  localparam int CNT_W      = 7;
  localparam int ITER_BITS  = 16;
  localparam int ABS_BITS   = 47;
  localparam int REL_BITS   = 32;
  localparam int CFG_W      = 47;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS-1:0]        mag_t;

  localparam value_t VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [GOLD_BITS-1:0] GOLD_Q64 = 64'h61C8864680B583EB;

  // result kinds
  localparam logic [1:0] KIND_EVAL  = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_LIMIT = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // search phase
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_PROBE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_ITER = 2'd0;
  localparam logic [1:0] CFG_ABS_TOL  = 2'd1;
  localparam logic [1:0] CFG_REL_TOL  = 2'd2;

  typedef struct packed {
    logic   action;
    value_t low_bound;
    value_t high_bound;
    value_t func_value;
  } req_t;

  typedef struct packed {
    value_t     point;
    logic [1:0] kind;
    value_t     min_value;
  } rsp_t;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic                 start;
    logic                 div;
    logic                 sh64;
    logic                 neg;
    mag_t                 a;
    logic [GOLD_BITS-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic   done;
    value_t value;
  } md_rsp_t;

  function automatic value_t sadd(value_t a, value_t b);
    logic [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) return s[VALUE_BITS] ? VMIN : VMAX;
    return value_t'(s[VALUE_BITS-1:0]);
  endfunction

  function automatic value_t ssub(value_t a, value_t b);
    logic [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) return s[VALUE_BITS] ? VMIN : VMAX;
    return value_t'(s[VALUE_BITS-1:0]);
  endfunction

  function automatic value_t sabs(value_t a);
    return a[VALUE_BITS-1] ? ssub('0, a) : a;
  endfunction

  // halve, rounding toward zero
  function automatic value_t half(value_t a);
    value_t t;
    t = a + value_t'(a[VALUE_BITS-1]);
    return t >>> 1;
  endfunction

  function automatic mag_t mag(value_t a);
    return a[VALUE_BITS-1] ? mag_t'(-a) : mag_t'(a);
  endfunction

  // signed fixed-point multiply request
  function automatic md_req_t smul_req(value_t a, value_t b);
    md_req_t r;
    r.start = 1'b1;
    r.div   = 1'b0;
    r.sh64  = 1'b0;
    r.neg   = a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
    r.a     = mag(a);
    r.b     = {{(GOLD_BITS-VALUE_BITS){1'b0}}, mag(b)};
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/blm_muldiv.sv -----
`default_nettype none
// Shared bit-serial unit: shift-add multiply (one multiplier bit a cycle) or
// restoring divide (one quotient bit a cycle), result saturated to the format.
module blm_muldiv (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire blm_pkg::md_req_t req,
  output blm_pkg::md_rsp_t     rsp
);

  logic                          busy;
  logic                          fin;
  logic                          div;
  logic                          sh64;
  logic                          neg;
  logic [blm_pkg::CNT_W-1:0]     cnt;
  logic [blm_pkg::PROD_W-1:0]    acc;
  logic [blm_pkg::PROD_W-1:0]    mcand;
  logic [blm_pkg::GOLD_BITS-1:0] mplier;
  logic [blm_pkg::VALUE_BITS:0]  rem;
  logic [blm_pkg::QUOT_W-1:0]    num;
  logic [blm_pkg::QUOT_W-1:0]    quot;
  logic [blm_pkg::VALUE_BITS-1:0] dvs;

  logic [blm_pkg::VALUE_BITS:0]  rem_sh;
  logic [blm_pkg::QUOT_W-1:0]    mag_q;
  logic [blm_pkg::QUOT_W-1:0]    lim;
  blm_pkg::value_t               sat;

  // one restoring step
  assign rem_sh = {rem[blm_pkg::VALUE_BITS-1:0], num[blm_pkg::QUOT_W-1]};

  // pick and saturate the magnitude
  always_comb begin
    if (div) begin
      mag_q = quot;
    end else if (sh64) begin
      mag_q = blm_pkg::QUOT_W'(acc[blm_pkg::PROD_W-1:blm_pkg::GOLD_BITS]);
    end else begin
      mag_q = acc[blm_pkg::FRAC_BITS +: blm_pkg::QUOT_W];
    end
    lim = blm_pkg::QUOT_W'(blm_pkg::VMAX) + blm_pkg::QUOT_W'(neg);
    if (mag_q > lim) begin
      sat = neg ? blm_pkg::VMIN : blm_pkg::VMAX;
    end else if (neg) begin
      sat = blm_pkg::value_t'(-mag_q[blm_pkg::VALUE_BITS-1:0]);
    end else begin
      sat = blm_pkg::value_t'(mag_q[blm_pkg::VALUE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      fin      <= 1'b0;
      if (fin) begin
        rsp.done  <= 1'b1;
        rsp.value <= sat;
      end
      if (req.start) begin
        busy   <= 1'b1;
        div    <= req.div;
        sh64   <= req.sh64;
        neg    <= req.neg;
        acc    <= '0;
        mcand  <= blm_pkg::PROD_W'(req.a);
        mplier <= req.b;
        rem    <= '0;
        num    <= {req.a, {blm_pkg::FRAC_BITS{1'b0}}};
        quot   <= '0;
        dvs    <= req.b[blm_pkg::VALUE_BITS-1:0];
        cnt    <= req.div ? blm_pkg::CNT_W'(blm_pkg::QUOT_W - 1)
                          : blm_pkg::CNT_W'(blm_pkg::GOLD_BITS - 1);
      end else if (busy) begin
        if (div) begin
          num <= num << 1;
          if (dvs != '0 && rem_sh >= {1'b0, dvs}) begin
            rem  <= rem_sh - {1'b0, dvs};
            quot <= {quot[blm_pkg::QUOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[blm_pkg::QUOT_W-2:0], 1'b0};
          end
        end else begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/brent_line_minimizer_top.sv -----
`default_nettype none
// Responses: a start request returns the first probe point; a value request
// returns an error when no search is open, a limit result at the iteration
// limit, a found result on a stop, or the next probe after a golden or a
// parabolic step (output stalls hold the result back). One request at a time;
// every product goes through the bit-serial multiply/divide unit that all share.
// Reset (rst, synchronous): search idle, all search state zero, registers at
// max_iterations 500, abs_tolerance 4295, rel_tolerance 64.
module brent_line_minimizer_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire blm_pkg::req_t             req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output blm_pkg::rsp_t                  rsp,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [blm_pkg::CFG_W-1:0] cfg_data
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_START = 16'h0002,
    S_HEAD  = 16'h0004,
    S_TOL   = 16'h0008,
    S_PR    = 16'h0010,
    S_PQ    = 16'h0020,
    S_PT    = 16'h0040,
    S_PP    = 16'h0080,
    S_PF    = 16'h0100,
    S_CQR   = 16'h0200,
    S_CQA   = 16'h0400,
    S_CQB   = 16'h0800,
    S_DIV   = 16'h1000,
    S_GOLD  = 16'h2000,
    S_FIN   = 16'h4000,
    S_EMIT  = 16'h8000
  } state_t;

  state_t state, state_next;

  logic [blm_pkg::ITER_BITS-1:0] max_iter;
  logic [blm_pkg::ABS_BITS-1:0]  abs_tol;
  logic [blm_pkg::REL_BITS-1:0]  rel_tol;

  blm_pkg::value_t bracket_low, bracket_low_next, bracket_high, bracket_high_next;
  blm_pkg::value_t best_x, best_x_next, second_x, second_x_next, third_x, third_x_next;
  blm_pkg::value_t best_f, best_f_next, second_f, second_f_next, third_f, third_f_next;
  blm_pkg::value_t prev_step, prev_step_next, last_step, last_step_next;
  blm_pkg::value_t probe_x, probe_x_next;
  logic [blm_pkg::ITER_BITS-1:0] iteration, iteration_next;
  logic [1:0]                    phase, phase_next;

  // per-iteration scratch
  blm_pkg::value_t m_reg, m_reg_next, tol_reg, tol_reg_next, t2_reg, t2_reg_next;
  blm_pkg::value_t p_reg, p_reg_next, q_reg, q_reg_next, r_reg, r_reg_next;
  blm_pkg::value_t qr_reg, qr_reg_next, qa_reg, qa_reg_next, d_reg, d_reg_next;
  blm_pkg::rsp_t   res, res_next;

  blm_pkg::md_req_t md_req;
  blm_pkg::md_rsp_t md_rsp;

  blm_pkg::value_t abst;
  logic            req_acc;
  logic            rsp_free;

  blm_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign abst      = blm_pkg::value_t'({1'b0, abs_tol});

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= blm_pkg::ITER_BITS'(500);
      abs_tol  <= blm_pkg::ABS_BITS'(4295);
      rel_tol  <= blm_pkg::REL_BITS'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        blm_pkg::CFG_MAX_ITER: max_iter <= cfg_data[blm_pkg::ITER_BITS-1:0];
        blm_pkg::CFG_ABS_TOL:  abs_tol  <= cfg_data[blm_pkg::ABS_BITS-1:0];
        blm_pkg::CFG_REL_TOL:  rel_tol  <= cfg_data[blm_pkg::REL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    blm_pkg::value_t f, tol_c, t2_c, u_c, q2, pn, step;
    state_next        = state;
    bracket_low_next  = bracket_low;
    bracket_high_next = bracket_high;
    best_x_next       = best_x;
    second_x_next     = second_x;
    third_x_next      = third_x;
    best_f_next       = best_f;
    second_f_next     = second_f;
    third_f_next      = third_f;
    prev_step_next    = prev_step;
    last_step_next    = last_step;
    probe_x_next      = probe_x;
    iteration_next    = iteration;
    phase_next        = phase;
    m_reg_next        = m_reg;
    tol_reg_next      = tol_reg;
    t2_reg_next       = t2_reg;
    p_reg_next        = p_reg;
    q_reg_next        = q_reg;
    r_reg_next        = r_reg;
    qr_reg_next       = qr_reg;
    qa_reg_next       = qa_reg;
    d_reg_next        = d_reg;
    res_next          = res;
    md_req            = '0;
    f     = req.func_value;
    tol_c = blm_pkg::sadd(md_rsp.value, abst);
    t2_c  = blm_pkg::sadd(tol_c, tol_c);
    u_c   = blm_pkg::sadd(best_x, md_rsp.value);
    q2    = blm_pkg::sadd(q_reg, q_reg);
    pn    = blm_pkg::ssub('0, p_reg);
    step  = (best_x < m_reg) ? blm_pkg::ssub(bracket_high, best_x)
                             : blm_pkg::ssub(bracket_low, best_x);

    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          if (!req.action) begin
            bracket_low_next  = req.low_bound;
            bracket_high_next = req.high_bound;
            md_req.start = 1'b1;
            md_req.sh64  = 1'b1;
            md_req.neg   = req.high_bound < req.low_bound;
            md_req.a     = blm_pkg::mag(blm_pkg::ssub(req.high_bound, req.low_bound));
            md_req.b     = blm_pkg::GOLD_Q64;
            state_next   = S_START;
          end else if (phase == blm_pkg::PH_IDLE) begin
            res_next   = '{point: '0, kind: blm_pkg::KIND_ERR, min_value: '0};
            state_next = S_EMIT;
          end else if (phase == blm_pkg::PH_FIRST) begin
            best_f_next   = f;
            second_f_next = f;
            third_f_next  = f;
            state_next    = S_HEAD;
          end else begin
            // bracket and best-three update at the last probe
            if (f <= best_f) begin
              if (probe_x < best_x) bracket_high_next = best_x;
              else bracket_low_next = best_x;
              third_x_next  = second_x;
              third_f_next  = second_f;
              second_x_next = best_x;
              second_f_next = best_f;
              best_x_next   = probe_x;
              best_f_next   = f;
            end else begin
              if (probe_x < best_x) bracket_low_next = probe_x;
              else bracket_high_next = probe_x;
              if (f <= second_f || second_x == best_x) begin
                third_x_next  = second_x;
                third_f_next  = second_f;
                second_x_next = probe_x;
                second_f_next = f;
              end else if (f <= third_f || third_x == best_x || third_x == second_x) begin
                third_x_next = probe_x;
                third_f_next = f;
              end
            end
            if (iteration != '1) iteration_next = iteration + 1'b1;
            state_next = S_HEAD;
          end
        end
      end
      S_START: begin
        if (md_rsp.done) begin
          best_x_next    = blm_pkg::sadd(bracket_low, md_rsp.value);
          second_x_next  = blm_pkg::sadd(bracket_low, md_rsp.value);
          third_x_next   = blm_pkg::sadd(bracket_low, md_rsp.value);
          probe_x_next   = blm_pkg::sadd(bracket_low, md_rsp.value);
          best_f_next    = '0;
          second_f_next  = '0;
          third_f_next   = '0;
          prev_step_next = '0;
          last_step_next = '0;
          iteration_next = '0;
          phase_next     = blm_pkg::PH_FIRST;
          res_next = '{point: blm_pkg::sadd(bracket_low, md_rsp.value),
                       kind: blm_pkg::KIND_EVAL, min_value: '0};
          state_next = S_EMIT;
        end
      end
      S_HEAD: begin
        if (iteration >= max_iter) begin
          phase_next = blm_pkg::PH_IDLE;
          res_next   = '{point: best_x, kind: blm_pkg::KIND_LIMIT, min_value: best_f};
          state_next = S_EMIT;
        end else begin
          m_reg_next   = blm_pkg::half(blm_pkg::sadd(bracket_low, bracket_high));
          md_req.start = 1'b1;
          md_req.a     = blm_pkg::mag(best_x);
          md_req.b     = blm_pkg::GOLD_BITS'(rel_tol);
          state_next   = S_TOL;
        end
      end
      S_TOL: begin
        if (md_rsp.done) begin
          tol_reg_next = tol_c;
          t2_reg_next  = t2_c;
          if (blm_pkg::sabs(blm_pkg::ssub(best_x, m_reg)) <=
              blm_pkg::ssub(t2_c, blm_pkg::half(blm_pkg::ssub(bracket_high, bracket_low))))
          begin
            phase_next = blm_pkg::PH_IDLE;
            res_next   = '{point: best_x, kind: blm_pkg::KIND_FOUND, min_value: best_f};
            state_next = S_EMIT;
          end else if (tol_c < blm_pkg::sabs(prev_step)) begin
            md_req     = blm_pkg::smul_req(blm_pkg::ssub(best_x, second_x),
                                           blm_pkg::ssub(best_f, third_f));
            state_next = S_PR;
          end else begin
            p_reg_next = '0;
            q_reg_next = '0;
            r_reg_next = '0;
            md_req     = blm_pkg::smul_req('0, '0);
            state_next = S_CQR;
          end
        end
      end
      // parabolic fit through x, w, v
      S_PR: begin
        if (md_rsp.done) begin
          r_reg_next = md_rsp.value;
          md_req     = blm_pkg::smul_req(blm_pkg::ssub(best_x, third_x),
                                         blm_pkg::ssub(best_f, second_f));
          state_next = S_PQ;
        end
      end
      S_PQ: begin
        if (md_rsp.done) begin
          q_reg_next = md_rsp.value;
          md_req     = blm_pkg::smul_req(blm_pkg::ssub(best_x, third_x), md_rsp.value);
          state_next = S_PT;
        end
      end
      S_PT: begin
        if (md_rsp.done) begin
          p_reg_next = md_rsp.value;
          md_req     = blm_pkg::smul_req(blm_pkg::ssub(best_x, second_x), r_reg);
          state_next = S_PP;
        end
      end
      S_PP: begin
        if (md_rsp.done) begin
          p_reg_next = blm_pkg::ssub(p_reg, md_rsp.value);
          q_reg_next = blm_pkg::ssub(q_reg, r_reg);
          state_next = S_PF;
        end
      end
      S_PF: begin
        if (q2 > 0) p_reg_next = pn;
        q_reg_next     = blm_pkg::sabs(q2);
        r_reg_next     = prev_step;
        prev_step_next = last_step;
        md_req         = blm_pkg::smul_req(blm_pkg::sabs(q2), prev_step);
        state_next     = S_CQR;
      end
      // acceptance products for the parabolic step
      S_CQR: begin
        if (md_rsp.done) begin
          qr_reg_next = md_rsp.value;
          md_req      = blm_pkg::smul_req(q_reg, blm_pkg::ssub(bracket_low, best_x));
          state_next  = S_CQA;
        end
      end
      S_CQA: begin
        if (md_rsp.done) begin
          qa_reg_next = md_rsp.value;
          md_req      = blm_pkg::smul_req(q_reg, blm_pkg::ssub(bracket_high, best_x));
          state_next  = S_CQB;
        end
      end
      S_CQB: begin
        if (md_rsp.done) begin
          if (blm_pkg::sabs(p_reg) < blm_pkg::sabs(blm_pkg::half(qr_reg)) &&
              qa_reg < p_reg && p_reg < md_rsp.value) begin
            md_req.start = 1'b1;
            md_req.div   = 1'b1;
            md_req.neg   = p_reg[blm_pkg::VALUE_BITS-1] ^ q_reg[blm_pkg::VALUE_BITS-1];
            md_req.a     = blm_pkg::mag(p_reg);
            md_req.b     = blm_pkg::GOLD_BITS'(blm_pkg::mag(q_reg));
            state_next   = S_DIV;
          end else begin
            prev_step_next = step;
            md_req.start   = 1'b1;
            md_req.sh64    = 1'b1;
            md_req.neg     = step[blm_pkg::VALUE_BITS-1];
            md_req.a       = blm_pkg::mag(step);
            md_req.b       = blm_pkg::GOLD_Q64;
            state_next     = S_GOLD;
          end
        end
      end
      S_DIV: begin
        if (md_rsp.done) begin
          d_reg_next = md_rsp.value;
          if (blm_pkg::ssub(u_c, bracket_low) < t2_reg ||
              blm_pkg::ssub(bracket_high, u_c) < t2_reg) begin
            d_reg_next = (best_x < m_reg) ? tol_reg : blm_pkg::ssub('0, tol_reg);
          end
          state_next = S_FIN;
        end
      end
      S_GOLD: begin
        if (md_rsp.done) begin
          d_reg_next = md_rsp.value;
          state_next = S_FIN;
        end
      end
      // keep the probe at least tol away from x
      S_FIN: begin
        last_step_next = d_reg;
        if (tol_reg <= blm_pkg::sabs(d_reg)) u_c = blm_pkg::sadd(best_x, d_reg);
        else if (d_reg > 0) u_c = blm_pkg::sadd(best_x, tol_reg);
        else u_c = blm_pkg::ssub(best_x, tol_reg);
        probe_x_next = u_c;
        phase_next   = blm_pkg::PH_PROBE;
        res_next     = '{point: u_c, kind: blm_pkg::KIND_EVAL, min_value: best_f};
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= blm_pkg::PH_IDLE;
      iteration    <= '0;
      bracket_low  <= '0;
      bracket_high <= '0;
      best_x       <= '0;
      second_x     <= '0;
      third_x      <= '0;
      best_f       <= '0;
      second_f     <= '0;
      third_f      <= '0;
      prev_step    <= '0;
      last_step    <= '0;
      probe_x      <= '0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      iteration    <= iteration_next;
      bracket_low  <= bracket_low_next;
      bracket_high <= bracket_high_next;
      best_x       <= best_x_next;
      second_x     <= second_x_next;
      third_x      <= third_x_next;
      best_f       <= best_f_next;
      second_f     <= second_f_next;
      third_f      <= third_f_next;
      prev_step    <= prev_step_next;
      last_step    <= last_step_next;
      probe_x      <= probe_x_next;
    end
  end

  // scratch, no reset
  always_ff @(posedge clk) begin
    m_reg  <= m_reg_next;
    tol_reg <= tol_reg_next;
    t2_reg <= t2_reg_next;
    p_reg  <= p_reg_next;
    q_reg  <= q_reg_next;
    r_reg  <= r_reg_next;
    qr_reg <= qr_reg_next;
    qa_reg <= qa_reg_next;
    d_reg  <= d_reg_next;
    res    <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_EMIT && rsp_free) begin
      rsp_valid <= 1'b1;
      rsp       <= res;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> state != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_md_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> (state != S_IDLE && state != S_EMIT && state != S_HEAD))
    else $error("multiply/divide result arrived with no step waiting");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && rsp_free) |=> rsp_valid)
    else $error("result not loaded into output register");

endmodule
`default_nettype wire
